FILE: src/lmds_pkg.sv
// shared types and constants for the led matrix scan core
package lmds_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // power-up frame pattern: first bytes of bank 0
    localparam logic [7:0] INIT_BYTE  = 8'hC0;
    localparam int         INIT_COUNT = 8;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    // classified operation handed to the back end
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } work_t;

    // queue side of the front/back link
    typedef struct packed {
        logic  valid;
        work_t item;
    } work_link_t;

endpackage

FILE: src/lmds_front.sv
// front end: accepts words, classifies commands and queues them for the back end
module lmds_front import lmds_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_write_data,
    output work_link_t q_link,
    input  logic       q_ready
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    work_t           slot_reg [QDEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;

    logic            accept;
    logic            push;
    logic            pop;
    work_t           item;

    // decode the command; the unused code is taken and dropped
    always_comb begin
        item.data = s_write_data;
        item.op   = OP_START;
        push      = 1'b0;
        unique case (s_command)
            CMD_START: begin
                item.op = OP_START;
                push    = 1'b1;
            end
            CMD_DATA: begin
                item.op = OP_DATA;
                push    = 1'b1;
            end
            CMD_TICK: begin
                item.op = OP_TICK;
                push    = 1'b1;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    assign s_ready = (count_reg != CW'(QDEPTH));
    assign accept  = s_valid && s_ready;
    assign pop     = q_link.valid && q_ready;

    // queue pointers
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (accept && push) begin
            wptr_next = (wptr_reg == PW'(QDEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(QDEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        priority if ((accept && push) && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (!(accept && push) && pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (accept && push) begin
            slot_reg[wptr_reg] <= item;
        end
    end

    assign q_link.valid = (count_reg != '0);
    assign q_link.item  = slot_reg[rptr_reg];

    // queue never overfills
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QDEPTH))
        else $error("queue count out of range");

    // a pop without a push empties by exactly one entry
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !(accept && push)) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("queue count not decremented on pop");

endmodule

FILE: src/lmds_back.sv
// back end: frame banks, write pointer, row scan and result register
module lmds_back import lmds_pkg::*; #(
    parameter int ROWS          = 8,
    parameter int BYTES_PER_ROW = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  work_link_t  q_link,
    output logic        q_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_row_enable,
    output logic [31:0] m_column_data,
    output logic        m_swap_flag
);

    localparam int RW    = $clog2(ROWS);
    localparam int BW    = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
    localparam int DEPTH = 2 * ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = 8 * BYTES_PER_ROW;

    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [BW-1:0] LAST_BYTE = BW'(BYTES_PER_ROW - 1);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t             state_reg, state_next;

    // frame store: one word per row, per-byte valid bits over the reset pattern
    logic [WW-1:0]            mem [DEPTH];
    logic [BYTES_PER_ROW-1:0] vld_reg [DEPTH];

    logic [RW-1:0] wr_row_reg, wr_row_next;
    logic [BW-1:0] wr_byte_reg, wr_byte_next;
    logic          full_reg, full_next;
    logic          front_bank_reg, front_bank_next;
    logic          swap_ind_reg, swap_ind_next;
    logic [RW-1:0] scan_row_reg, scan_row_next;
    logic          bank_latch_reg, bank_latch_next;
    logic          flag_start_reg, flag_start_next;
    logic          out_valid_reg, out_valid_next;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     rd_bank;

    logic [WW-1:0]            rd_word_reg;
    logic [BYTES_PER_ROW-1:0] rd_valid_reg;
    logic                     rd_bank_reg;
    logic [RW-1:0]            rd_row_reg;
    logic                     rd_swap_reg;

    logic [7:0]  row_enable_reg;
    logic [31:0] column_data_reg;
    logic        swap_flag_reg;

    logic        pop;
    logic [7:0]  col_byte [4];
    logic [4:0]  row_wide;

    // back bank address for writes, latched bank address for row reads
    assign wr_addr = front_bank_reg ? AW'(wr_row_reg) : AW'(ROWS) + AW'(wr_row_reg);
    assign rd_bank = (scan_row_reg == LAST_ROW) ? front_bank_reg : bank_latch_reg;
    assign rd_addr = rd_bank ? AW'(ROWS) + AW'(scan_row_reg) : AW'(scan_row_reg);

    assign pop = q_link.valid && q_ready;

    // operation sequencer
    always_comb begin
        state_next      = state_reg;
        wr_row_next     = wr_row_reg;
        wr_byte_next    = wr_byte_reg;
        full_next       = full_reg;
        front_bank_next = front_bank_reg;
        swap_ind_next   = swap_ind_reg;
        scan_row_next   = scan_row_reg;
        bank_latch_next = bank_latch_reg;
        flag_start_next = flag_start_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        q_ready         = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                q_ready = (q_link.item.op != OP_TICK) || !out_valid_reg || m_ready;
                if (pop) begin
                    unique case (q_link.item.op)
                        OP_START: begin
                            wr_row_next  = '0;
                            wr_byte_next = '0;
                            full_next    = 1'b0;
                        end
                        OP_DATA: begin
                            if (!full_reg) begin
                                wr_en = 1'b1;
                                if (wr_byte_reg == LAST_BYTE) begin
                                    wr_byte_next = '0;
                                    if (wr_row_reg == LAST_ROW) begin
                                        full_next   = 1'b1;
                                        wr_row_next = '0;
                                    end else begin
                                        wr_row_next = wr_row_reg + RW'(1);
                                    end
                                end else begin
                                    wr_byte_next = wr_byte_reg + BW'(1);
                                end
                            end else begin
                                swap_ind_next   = 1'b1;
                                front_bank_next = !front_bank_reg;
                            end
                        end
                        OP_TICK: begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                            if (scan_row_reg == LAST_ROW) begin
                                bank_latch_next = front_bank_reg;
                                flag_start_next = swap_ind_reg;
                            end
                            if (scan_row_reg == '0) begin
                                if (flag_start_reg) begin
                                    swap_ind_next = 1'b0;
                                end
                                scan_row_next = LAST_ROW;
                            end else begin
                                scan_row_next = scan_row_reg - RW'(1);
                            end
                        end
                        default: begin
                            state_next = ST_RUN;
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_valid_next = 1'b1;
                state_next     = ST_RUN;
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            wr_row_reg     <= '0;
            wr_byte_reg    <= '0;
            full_reg       <= 1'b0;
            front_bank_reg <= 1'b0;
            swap_ind_reg   <= 1'b0;
            scan_row_reg   <= LAST_ROW;
            bank_latch_reg <= 1'b0;
            flag_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wr_row_reg     <= wr_row_next;
            wr_byte_reg    <= wr_byte_next;
            full_reg       <= full_next;
            front_bank_reg <= front_bank_next;
            swap_ind_reg   <= swap_ind_next;
            scan_row_reg   <= scan_row_next;
            bank_latch_reg <= bank_latch_next;
            flag_start_reg <= flag_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // frame store write and registered row read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr][8*wr_byte_reg +: 8] <= q_link.item.data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
            rd_bank_reg <= rd_bank;
            rd_row_reg  <= scan_row_reg;
            rd_swap_reg <= swap_ind_reg;
        end
    end

    // written-byte flags, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                vld_reg[i] <= '0;
            end
            rd_valid_reg <= '0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr][wr_byte_reg] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= vld_reg[rd_addr];
            end
        end
    end

    // column bytes: stored byte, or the power-up pattern if never written (zero outside the pattern)
    for (genvar j = 0; j < 4; j++) begin : g_col
        if (j < BYTES_PER_ROW) begin : g_byte
            logic init_hit;
            assign init_hit = !rd_bank_reg &&
                ((int'(rd_row_reg) * BYTES_PER_ROW + j) < INIT_COUNT);
            assign col_byte[j] = rd_valid_reg[j] ? rd_word_reg[8*j +: 8] :
                                 (init_hit ? INIT_BYTE : 8'h00);
        end else begin : g_pad
            assign col_byte[j] = 8'h00;
        end
    end

    assign row_wide = 5'(rd_row_reg);

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            row_enable_reg  <= (row_wide < 5'd8) ? (8'd1 << row_wide[2:0]) : 8'd0;
            column_data_reg <= {col_byte[3], col_byte[2], col_byte[1], col_byte[0]};
            swap_flag_reg   <= rd_swap_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_row_enable  = row_enable_reg;
    assign m_column_data = column_data_reg;
    assign m_swap_flag   = swap_flag_reg;

    // the read state always hands back to the run state in the next cycle
    a_read_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_RUN))
        else $error("read state held longer than one cycle");

    // a row result never lands on an undelivered word
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("result register overwritten");

    // a full bank parks the pointer at the start
    a_full_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (wr_row_reg == '0) && (wr_byte_reg == '0))
        else $error("write pointer moved past end of bank");

    // scan row stays inside the matrix
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_row_reg <= LAST_ROW)
        else $error("scan row out of range");

endmodule

FILE: src/led_matrix_double_buffer_scan_core.sv
// top level: double-buffered led matrix row scan core
// a row tick word passes through the queue, the registered row read and the result register
// throughput: start and data words one per cycle while no row tick holds the back end
// a row tick waits for a free result register, then blocks the queue during its row read
// reset: synchronous active-low aresetn clears pointers and queue; scan row set to last
// written-byte flags clear in reset; unwritten bytes read as the power-up frame
module led_matrix_double_buffer_scan_core import lmds_pkg::*; #(
    parameter int ROWS          = 8,
    parameter int BYTES_PER_ROW = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_row_enable,
    output logic [31:0] m_column_data,
    output logic        m_swap_flag
);

    work_link_t q_link;
    logic       q_ready;

    // accept and classify
    lmds_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_write_data (s_write_data),
        .q_link       (q_link),
        .q_ready      (q_ready)
    );

    // frame store and scan
    lmds_back #(
        .ROWS          (ROWS),
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_link        (q_link),
        .q_ready       (q_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_enable  (m_row_enable),
        .m_column_data (m_column_data),
        .m_swap_flag   (m_swap_flag)
    );

endmodule
